[rtl/roq_pkg.sv]
// ----------------------------------------------------------------------------
// roq_pkg
// Shared types, sizes and the exponential table of the occupancy query unit.
// ----------------------------------------------------------------------------
package roq_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int EXP_DEPTH  = 256;
    localparam int EXP_IDX_W  = $clog2(EXP_DEPTH);
    localparam int STEP_SHIFT = 12;
    localparam int FEAT_W     = 17;
    localparam int LS_W       = 24;
    localparam int W_W        = 24;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 2'd1;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [ADDR_W-1:0]  entry_index;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
        logic signed [23:0] weight_value;
    } t_in_beat;

    typedef struct packed {
        logic [15:0]        occupancy_probability;
        logic signed [31:0] logit_sum;
    } t_out_beat;

    // One stored support point
    typedef struct packed {
        logic signed [31:0]    px;
        logic signed [31:0]    py;
        logic signed [31:0]    pz;
        logic signed [W_W-1:0] w;
    } t_point;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_SIG,
        ST_HOLD
    } t_state;

    typedef logic [FEAT_W-1:0] t_exp_tab [EXP_DEPTH];

    // exp(-k/16) in Q1.16, built by repeated multiply with exp(-1/16) in Q0.32
    function automatic t_exp_tab f_exp_tab();
        logic [63:0] e;
        t_exp_tab    t;
        e = 64'h1_0000_0000;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            t[k] = FEAT_W'((e + 64'd32768) >> 16);
            e    = (e * 64'd4034748382 + 64'h8000_0000) >> 32;
        end
        return t;
    endfunction

    localparam t_exp_tab EXP_TAB = f_exp_tab();

endpackage

[rtl/roq_point_mem.sv]
// ----------------------------------------------------------------------------
// roq_point_mem
// Support point store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module roq_point_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [roq_pkg::ADDR_W-1:0] i_wr_addr,
    input  roq_pkg::t_point            i_wr_data,
    input  logic                       i_rd_en,
    input  logic [roq_pkg::ADDR_W-1:0] i_rd_addr,
    output logic                       o_rd_valid,
    output roq_pkg::t_point            o_rd_data
);

    roq_pkg::t_point r_mem [roq_pkg::MAX_POINTS];
    roq_pkg::t_point r_rd_data;
    logic            r_rd_valid;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data registered and valid in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd_en;
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_data  = r_rd_data;

endmodule

[rtl/roq_kernel_pipe.sv]
// ----------------------------------------------------------------------------
// roq_kernel_pipe
// Per-point kernel pipeline: distance, exponential feature, weighted sum.
// ----------------------------------------------------------------------------
module roq_kernel_pipe (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr,
    input  logic                     i_valid,
    input  roq_pkg::t_point          i_point,
    input  logic signed [31:0]       i_qx,
    input  logic signed [31:0]       i_qy,
    input  logic signed [31:0]       i_qz,
    input  logic [roq_pkg::LS_W-1:0] i_length_scale,
    output logic                     o_busy,
    output logic signed [31:0]       o_acc
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_vld;

    // stage payloads
    logic [32:0]                     r_ax, r_ay, r_az;
    logic signed [roq_pkg::W_W-1:0]  r_w1, r_w2, r_w3, r_w4, r_w5;
    logic [49:0]                     r_sqx, r_sqy, r_sqz;
    logic [31:0]                     r_d;
    logic [55:0]                     r_argp;
    logic [roq_pkg::FEAT_W-1:0]      r_feat;
    logic signed [41:0]              r_prod;
    logic signed [31:0]              r_acc;

    logic signed [32:0] dx, dy, dz;
    logic [65:0]        sqx, sqy, sqz;
    logic [51:0]        dsum;
    logic signed [41:0] rnd;
    logic signed [25:0] contrib;
    logic signed [33:0] acc_sum;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // stage 1: absolute axis differences
    always_comb begin
        dx = 33'(i_point.px) - 33'(i_qx);
        dy = 33'(i_point.py) - 33'(i_qy);
        dz = 33'(i_point.pz) - 33'(i_qz);
    end

    always_ff @(posedge i_clk) begin
        r_ax <= dx[32] ? 33'(-dx) : 33'(dx);
        r_ay <= dy[32] ? 33'(-dy) : 33'(dy);
        r_az <= dz[32] ? 33'(-dz) : 33'(dz);
        r_w1 <= i_point.w;
    end

    // stage 2: squares in Q34.16
    assign sqx = 66'(r_ax) * 66'(r_ax);
    assign sqy = 66'(r_ay) * 66'(r_ay);
    assign sqz = 66'(r_az) * 66'(r_az);

    always_ff @(posedge i_clk) begin
        r_sqx <= sqx[65:16];
        r_sqy <= sqy[65:16];
        r_sqz <= sqz[65:16];
        r_w2  <= r_w1;
    end

    // stage 3: distance sum, saturated to 32 bits
    assign dsum = 52'(r_sqx) + 52'(r_sqy) + 52'(r_sqz);

    always_ff @(posedge i_clk) begin
        r_d  <= (dsum[51:32] != '0) ? 32'hFFFF_FFFF : dsum[31:0];
        r_w3 <= r_w2;
    end

    // stage 4: scale by kernel sharpness
    always_ff @(posedge i_clk) begin
        r_argp <= 56'(r_d) * 56'(i_length_scale);
        r_w4   <= r_w3;
    end

    // stage 5: table lookup; argument >> 12 beyond the table gives zero
    always_ff @(posedge i_clk) begin
        if (r_argp[55:28+roq_pkg::EXP_IDX_W] != '0) begin
            r_feat <= '0;
        end else begin
            r_feat <= roq_pkg::EXP_TAB[r_argp[28 +: roq_pkg::EXP_IDX_W]];
        end
        r_w5 <= r_w4;
    end

    // stage 6: weight times feature
    always_ff @(posedge i_clk) begin
        r_prod <= 42'(r_w5) * $signed({25'd0, r_feat});
    end

    // stage 7: round half up to Q16.16, saturating accumulate
    assign rnd     = r_prod + 42'sd32768;
    assign contrib = rnd[41:16];
    assign acc_sum = 34'(r_acc) + 34'(contrib);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_acc <= '0;
        end else if (r_vld[NSTG-1]) begin
            if (acc_sum > 34'sh0_7FFF_FFFF) begin
                r_acc <= 32'sh7FFF_FFFF;
            end else if (acc_sum < -34'sh0_8000_0000) begin
                r_acc <= 32'sh8000_0000;
            end else begin
                r_acc <= acc_sum[31:0];
            end
        end
    end

    assign o_busy = |r_vld;
    assign o_acc  = r_acc;

endmodule

[rtl/roq_sigmoid.sv]
// ----------------------------------------------------------------------------
// roq_sigmoid
// Sigmoid of the logit: table lookup and a bit-serial rounding divider.
// ----------------------------------------------------------------------------
module roq_sigmoid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_logit,
    output logic               o_done,
    output logic [15:0]        o_prob
);

    localparam int NUM_W = 33;
    localparam int DEN_W = 18;
    localparam int REM_W = DEN_W + 1;
    localparam int Q_W   = 17;

    logic                   r_busy;
    logic [5:0]             r_cnt;
    logic [NUM_W-1:0]       r_num;
    logic [REM_W-1:0]       r_rem;
    logic [DEN_W-1:0]       r_den;
    logic [Q_W-1:0]         r_q;
    logic                   r_neg;
    logic                   r_done;
    logic [15:0]            r_prob;

    logic [31:0]            mag;
    logic [DEN_W-1:0]       den;
    logic [REM_W-1:0]       trial;
    logic                   qbit;
    logic [Q_W-1:0]         q_next;

    assign mag = i_logit[31] ? 32'(-i_logit) : 32'(i_logit);
    assign den = DEN_W'(65536) + DEN_W'(roq_pkg::EXP_TAB[mag[12 +: roq_pkg::EXP_IDX_W]]);

    // one quotient bit per cycle
    assign trial  = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign qbit   = (trial >= REM_W'(r_den));
    assign q_next = {r_q[Q_W-2:0], qbit};

    // final probability from quotient s
    function automatic logic [15:0] f_prob(input logic neg, input logic [Q_W-1:0] s);
        logic [Q_W-1:0] d;
        d = Q_W'(65536) - s;
        if (neg) begin
            return d[15:0];
        end
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (mag[31:12+roq_pkg::EXP_IDX_W] != '0) begin
                    // far from zero: s is exactly one
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == 6'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_logit[31];
            r_cnt <= '0;
            r_rem <= '0;
            r_q   <= '0;
            r_den <= den;
            r_num <= {1'b1, 32'(den >> 1)};
            if (mag[31:12+roq_pkg::EXP_IDX_W] != '0) begin
                r_prob <= f_prob(i_logit[31], Q_W'(65536));
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= qbit ? REM_W'(trial - REM_W'(r_den)) : trial;
            r_q   <= q_next;
            if (r_cnt == 6'(NUM_W - 1)) begin
                r_prob <= f_prob(r_neg, q_next);
            end
        end
    end

    assign o_done = r_done;
    assign o_prob = r_prob;

endmodule

[rtl/rbf_occupancy_query_unit.sv]
// ----------------------------------------------------------------------------
// rbf_occupancy_query_unit
// RBF occupancy query over up to 1024 stored support points.
// ----------------------------------------------------------------------------
// Input beats carry either a load (req_type 0) or a query (req_type 1).
// A load writes point and weight into slot entry_index and gives no
// output beat. A query walks slots 0 .. min(num_points,1024)-1,
// reading one slot per cycle from the point memory into a 7-stage kernel
// pipeline, then runs a bit-serial divider for the sigmoid; the divide is
// skipped when |logit| >= 16.0. The next input beat can be taken in the
// same cycle as the result beat becomes valid.
// One item is in work at a time: o_in_stall is high from query accept to
// result hand-off. The result sits in an output register; the next item is
// accepted while it waits, and a stalled result holds until i_out_stall drops.
// Config writes (index 0 length_scale, 1 num_points) are always ready.
// The user must make config writes while idle; the block does not enforce
// it. Reset sets length_scale 1.0 and num_points 1024; point memory
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module rbf_occupancy_query_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  roq_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output roq_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [roq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]                   i_cfg_data
);

    roq_pkg::t_state r_state, n_state;

    logic [roq_pkg::LS_W-1:0]  r_length_scale;
    logic [roq_pkg::CNT_W-1:0] r_num_points;
    logic [roq_pkg::CNT_W-1:0] r_n;
    logic [roq_pkg::CNT_W-1:0] r_cnt;
    logic signed [31:0]        r_qx, r_qy, r_qz;
    logic                      r_out_valid;
    roq_pkg::t_out_beat        r_out;

    logic              in_acc, is_load, is_query;
    logic              rd_en, sig_start, out_load;
    logic              rd_valid, pipe_busy, sig_done;
    roq_pkg::t_point   rd_data, wr_data;
    logic signed [31:0] acc;
    logic [15:0]       prob;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_load  = in_acc && (i_in_data.req_type == roq_pkg::REQ_LOAD);
    assign is_query = in_acc && (i_in_data.req_type == roq_pkg::REQ_QUERY);

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_scale <= 24'd65536;
            r_num_points   <= roq_pkg::CNT_W'(roq_pkg::MAX_POINTS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                roq_pkg::CFG_LENGTH_SCALE: r_length_scale <= i_cfg_data;
                roq_pkg::CFG_NUM_POINTS:   r_num_points   <= i_cfg_data[roq_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            roq_pkg::ST_IDLE:  if (is_query) n_state = roq_pkg::ST_WALK;
            roq_pkg::ST_WALK:  if (r_cnt >= r_n) n_state = roq_pkg::ST_DRAIN;
            roq_pkg::ST_DRAIN: if (!pipe_busy && !rd_valid) n_state = roq_pkg::ST_SIG;
            roq_pkg::ST_SIG:   if (sig_done) n_state = roq_pkg::ST_HOLD;
            roq_pkg::ST_HOLD:  if (!r_out_valid || !i_out_stall) n_state = roq_pkg::ST_IDLE;
            default:           n_state = roq_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        rd_en      = 1'b0;
        sig_start  = 1'b0;
        out_load   = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            roq_pkg::ST_IDLE:  o_in_stall = 1'b0;
            roq_pkg::ST_WALK:  rd_en = (r_cnt < r_n);
            roq_pkg::ST_DRAIN: sig_start = !pipe_busy && !rd_valid;
            roq_pkg::ST_SIG:   ;
            roq_pkg::ST_HOLD:  out_load = !r_out_valid || !i_out_stall;
            default:           ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= roq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Query setup and slot counter
    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_qx  <= i_in_data.x_coord;
            r_qy  <= i_in_data.y_coord;
            r_qz  <= i_in_data.z_coord;
            r_cnt <= '0;
            r_n   <= (r_num_points > roq_pkg::CNT_W'(roq_pkg::MAX_POINTS)) ?
                     roq_pkg::CNT_W'(roq_pkg::MAX_POINTS) : r_num_points;
        end else if (rd_en) begin
            r_cnt <= r_cnt + roq_pkg::CNT_W'(1);
        end
    end

    // Point memory
    assign wr_data = '{px: i_in_data.x_coord, py: i_in_data.y_coord,
                       pz: i_in_data.z_coord, w: i_in_data.weight_value};

    roq_point_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (is_load),
        .i_wr_addr  (i_in_data.entry_index),
        .i_wr_data  (wr_data),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_cnt[roq_pkg::ADDR_W-1:0]),
        .o_rd_valid (rd_valid),
        .o_rd_data  (rd_data)
    );

    roq_kernel_pipe u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clr          (is_query),
        .i_valid        (rd_valid),
        .i_point        (rd_data),
        .i_qx           (r_qx),
        .i_qy           (r_qy),
        .i_qz           (r_qz),
        .i_length_scale (r_length_scale),
        .o_busy         (pipe_busy),
        .o_acc          (acc)
    );

    roq_sigmoid u_sig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sig_start),
        .i_logit (acc),
        .o_done  (sig_done),
        .o_prob  (prob)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.occupancy_probability <= prob;
            r_out.logit_sum             <= acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_rd_only_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_state == roq_pkg::ST_WALK) && !is_load)
        else $error("point memory read outside the walk");

    a_sig_in_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sig_done |-> (r_state == roq_pkg::ST_SIG))
        else $error("sigmoid done outside its state");

    a_prob_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out.logit_sum[31] ? (r_out.occupancy_probability <= 16'd32768)
                                          : (r_out.occupancy_probability >= 16'd32768)))
        else $error("probability on wrong side of one half");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rbf_occupancy_query_unit: loads support points,
// runs occupancy queries under several kernel widths and point counts, and
// compares every output beat with a cycle-free prediction of logit and
// probability. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the two real registers; writes there do nothing
    localparam logic [roq_pkg::CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [roq_pkg::CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;
    localparam int TAB_DEPTH = 256;
    // Slots written by the saturation test; queries never walk past them later
    localparam int SAT_SLOTS = 262;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    roq_pkg::t_in_beat             i_in_data = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    roq_pkg::t_out_beat            o_out_data;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [roq_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [23:0]                   i_cfg_data = '0;

    rbf_occupancy_query_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bench copy of stored points, registers and lookup tables
    logic signed [31:0] slot_x [roq_pkg::MAX_POINTS];
    logic signed [31:0] slot_y [roq_pkg::MAX_POINTS];
    logic signed [31:0] slot_z [roq_pkg::MAX_POINTS];
    logic signed [23:0] slot_w [roq_pkg::MAX_POINTS];
    longint unsigned    kernel_scale;
    longint unsigned    walk_count;
    longint unsigned    exp_q16 [TAB_DEPTH];
    longint unsigned    sigmoid_q16 [TAB_DEPTH];

    roq_pkg::t_out_beat expected_occupancy [$];
    int errors;
    int loads_sent;
    int queries_sent;
    int results_seen;
    bit calm;

    // exp(-k/16) in Q1.16 and the matching rounded sigmoid divisor result
    function automatic void build_tables();
        longint unsigned e;
        longint unsigned den;
        e = 64'h1_0000_0000;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            exp_q16[k]     = (e + 64'd32768) >> 16;
            den            = 64'd65536 + exp_q16[k];
            sigmoid_q16[k] = (64'h1_0000_0000 + den / 2) / den;
            e              = (e * 64'd4034748382 + 64'h8000_0000) >> 32;
        end
    endfunction

    function automatic longint unsigned sq_diff(logic signed [31:0] a, logic signed [31:0] b);
        longint          dv;
        longint unsigned m;
        dv = longint'(a) - longint'(b);
        m  = (dv < 0) ? longint'(-dv) : dv;
        return (m * m) >> 16;
    endfunction

    // Update the store for a load, or queue the expected reading of a query
    function automatic void apply_beat(roq_pkg::t_in_beat b);
        longint unsigned sq_dist, arg, idx, feat, mag, s, n;
        longint          acc, prod;
        roq_pkg::t_out_beat r;
        if (b.req_type == roq_pkg::REQ_LOAD) begin
            slot_x[b.entry_index] = b.x_coord;
            slot_y[b.entry_index] = b.y_coord;
            slot_z[b.entry_index] = b.z_coord;
            slot_w[b.entry_index] = b.weight_value;
            return;
        end
        acc = 0;
        n = (walk_count > roq_pkg::MAX_POINTS) ? roq_pkg::MAX_POINTS : walk_count;
        for (int i = 0; i < n; i++) begin
            sq_dist = sq_diff(slot_x[i], b.x_coord) + sq_diff(slot_y[i], b.y_coord)
                    + sq_diff(slot_z[i], b.z_coord);
            if (sq_dist > 64'hFFFF_FFFF) sq_dist = 64'hFFFF_FFFF;
            arg  = (sq_dist * kernel_scale) >> 16;
            idx  = arg >> roq_pkg::STEP_SHIFT;
            feat = (idx < TAB_DEPTH) ? exp_q16[idx] : 0;
            prod = longint'(slot_w[i]) * longint'(feat);
            acc += (prod + 32768) >>> 16;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        end
        mag = (acc < 0) ? longint'(-acc) : acc;
        idx = mag >> roq_pkg::STEP_SHIFT;
        s   = (idx < TAB_DEPTH) ? sigmoid_q16[idx] : 65536;
        if (acc >= 0) r.occupancy_probability = (s > 65535) ? 16'hFFFF : s[15:0];
        else          r.occupancy_probability = 16'(65536 - s);
        r.logit_sum = acc[31:0];
        expected_occupancy = {expected_occupancy, r};
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Output checker: one beat against the oldest expected reading
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_occupancy.size() == 0) begin
                report("unexpected beat, logit", o_out_data.logit_sum, 0);
            end else begin
                if (o_out_data.logit_sum !== expected_occupancy[0].logit_sum)
                    report("logit", o_out_data.logit_sum, expected_occupancy[0].logit_sum);
                if (o_out_data.occupancy_probability !==
                    expected_occupancy[0].occupancy_probability)
                    report("probability", o_out_data.occupancy_probability,
                           expected_occupancy[0].occupancy_probability);
                void'(expected_occupancy.pop_front());
            end
        end
    end

    // Receiver stall bursts
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (calm) begin
            stall_left  = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left  = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Send one beat; returns at the falling edge after acceptance
    task automatic send_beat(roq_pkg::t_in_beat b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        apply_beat(b);
        if (b.req_type == roq_pkg::REQ_LOAD) loads_sent++;
        else queries_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_slot(int slot, int x, int y, int z, int w);
        roq_pkg::t_in_beat b;
        b.req_type     = roq_pkg::REQ_LOAD;
        b.entry_index  = slot[roq_pkg::ADDR_W-1:0];
        b.x_coord      = x;
        b.y_coord      = y;
        b.z_coord      = z;
        b.weight_value = w[23:0];
        send_beat(b);
    endtask

    task automatic query_at(int x, int y, int z);
        roq_pkg::t_in_beat b;
        b              = roq_pkg::t_in_beat'({$urandom, $urandom, $urandom, $urandom});
        b.req_type     = roq_pkg::REQ_QUERY;
        b.x_coord      = x;
        b.y_coord      = y;
        b.z_coord      = z;
        send_beat(b);
    endtask

    // Wait for every reading, then a margin for the unit to settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_occupancy.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    // One register write with the input side quiet
    task automatic write_reg(logic [roq_pkg::CFG_IDX_W-1:0] idx, int value);
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[23:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == roq_pkg::CFG_LENGTH_SCALE) kernel_scale = value[23:0];
        else if (idx == roq_pkg::CFG_NUM_POINTS) walk_count = value[10:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Field extremes on a handful of slots
    task automatic test_edge_points();
        write_reg(roq_pkg::CFG_NUM_POINTS, 8);
        load_slot(0, 0, 0, 0, 24'sh7FFFFF);
        load_slot(1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -8388608);
        load_slot(2, 32'sh80000000, 32'sh80000000, 32'sh80000000, 65536);
        load_slot(3, 65536, -65536, 32768, -65536);
        load_slot(4, 0, 65536, 0, 0);
        load_slot(5, -131072, 0, 131072, 12345);
        load_slot(6, 1, -1, 1, -1);
        load_slot(7, 0, 0, 65536, 24'sh7FFFFF);
        query_at(0, 0, 0);
        query_at(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        query_at(32'sh80000000, 32'sh80000000, 32'sh80000000);
        query_at(65536, -65536, 32768);
        query_at(32'sh7FFFFFFF, 32'sh80000000, 0);
        drain();
        write_reg(roq_pkg::CFG_NUM_POINTS, 1);
        query_at(0, 0, 0);
        query_at(4096, 0, 0);
        drain();
        write_reg(roq_pkg::CFG_NUM_POINTS, 0);     // no points: logit zero
        query_at(0, 0, 0);
        drain();
        write_reg(CFG_UNUSED_2, 24'hFFFFFF);       // beyond the register file
        write_reg(CFG_UNUSED_3, 5);
        write_reg(roq_pkg::CFG_NUM_POINTS, 8);
        query_at(-65536, 65536, 0);
        drain();
    endtask

    // Drive the logit into its upper limit, then pull it back down from there
    task automatic test_saturation();
        for (int i = 0; i < SAT_SLOTS - 4; i++) load_slot(i, 0, 0, 0, 24'sh7FFFFF);
        for (int i = SAT_SLOTS - 4; i < SAT_SLOTS; i++) load_slot(i, 0, 0, 0, -8388608);
        write_reg(roq_pkg::CFG_NUM_POINTS, SAT_SLOTS - 4);
        query_at(0, 0, 0);
        query_at(1000, -1000, 0);
        drain();
        write_reg(roq_pkg::CFG_NUM_POINTS, SAT_SLOTS);
        query_at(0, 0, 0);
        drain();
        write_reg(roq_pkg::CFG_LENGTH_SCALE, 0);   // every feature is one
        query_at(32'sh7FFFFFFF, 0, 32'sh80000000);
        drain();
    endtask

    // Kernel width sweep over a spread of points
    task automatic test_kernel_width();
        int scales [5] = '{0, 1, 4096, 65536, 24'hFFFFFF};
        for (int i = 0; i < 64; i++)
            load_slot(i, $urandom_range(0, 262144) - 131072, $urandom_range(0, 262144) - 131072,
                      $urandom_range(0, 262144) - 131072, $urandom_range(0, 24'hFFFFFF));
        write_reg(roq_pkg::CFG_NUM_POINTS, 64);
        foreach (scales[k]) begin
            drain();
            write_reg(roq_pkg::CFG_LENGTH_SCALE, scales[k]);
            repeat (3) query_at($urandom_range(0, 131072) - 65536,
                                $urandom_range(0, 131072) - 65536, 0);
        end
        drain();
    endtask

    // Random rounds of loads and queries under random settings
    task automatic test_random_traffic();
        int span;
        for (int round = 0; round < 11; round++) begin
            if (round >= 9) calm = 1'b1;
            drain();
            write_reg(roq_pkg::CFG_LENGTH_SCALE,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                  : $urandom_range(256, 262144));
            write_reg(roq_pkg::CFG_NUM_POINTS,
                      ($urandom_range(0, 14) == 0) ? $urandom_range(1, SAT_SLOTS)
                                                   : $urandom_range(1, 48));
            span = ($urandom_range(0, 1) == 0) ? 65536 : 524288;
            for (int k = 0; k < 20; k++) begin
                if (k == 10 && round % 5 == 2) drain();
                if ($urandom_range(0, 9) == 0) begin
                    // full-range noise
                    if ($urandom_range(0, 1) == 0)
                        load_slot($urandom_range(0, 1023), $urandom, $urandom, $urandom, $urandom);
                    else
                        query_at($urandom, $urandom, $urandom);
                end else if ($urandom_range(0, 9) < 6) begin
                    load_slot($urandom_range(0, 63), $urandom_range(0, 2 * span) - span,
                              $urandom_range(0, 2 * span) - span,
                              $urandom_range(0, 2 * span) - span,
                              $urandom_range(0, 24'hFFFFFF));
                end else begin
                    query_at($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                             $urandom_range(0, 2 * span) - span);
                end
            end
        end
        drain();
    endtask

    initial begin
        build_tables();
        kernel_scale = 65536;
        walk_count   = 1024;
        calm         = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_edge_points();
        test_saturation();
        test_kernel_width();
        test_random_traffic();
        repeat (100) @(negedge i_clk);
        $display("covered %0d loads and %0d queries, %0d readings checked",
                 loads_sent, queries_sent, results_seen);
        $display("point counts 0..%0d, kernel widths 0..max, logit clipping and recovery",
                 SAT_SLOTS);
        if (errors == 0 && expected_occupancy.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d errors, %0d readings missing", errors, expected_occupancy.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
